### hw/rtl/triangle_edge_walker_core_assert.svh
// assertion macros for the edge walker checker
// no dependencies
`ifndef TRIANGLE_EDGE_WALKER_CORE_ASSERT_SVH
`define TRIANGLE_EDGE_WALKER_CORE_ASSERT_SVH
`define TEW_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define TEW_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### hw/rtl/tew_pkg.sv
// package for the triangle edge walker: types, codes, constants
// no dependencies
package tew_pkg;
  localparam int COMPONENTS_DEF = 12;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int ROW_BITS_DEF = 12;
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_STEP = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] KIND_EDGE = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_STEP = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_PRE, ST_EDGE, ST_LM1, ST_LM2, ST_LM3, ST_LSUM, ST_LOUT,
    ST_SRD, ST_SOUT
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic signed [31:0] top_x;
    logic signed [31:0] top_y;
    logic signed [31:0] bottom_x;
    logic signed [31:0] bottom_y;
    logic [3:0] component_index;
    logic signed [31:0] attr_value;
    logic signed [31:0] attr_dfdx;
    logic signed [31:0] attr_dfdy;
  } edge_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic status;
    logic [11:0] row_first;
    logic [11:0] row_last;
    logic signed [31:0] x_current;
    logic [3:0] out_component;
    logic signed [31:0] component_value;
    logic last;
  } walk_result_t;

  typedef struct packed {
    logic start;
    logic signed [63:0] num;
    logic signed [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [63:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

### hw/rtl/tew_if.sv
// valid/ready channel interface with generic payload
// depends on nothing
interface tew_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/triangle_edge_walker_core.sv
// edge start: states DIV (dedicated divider), PRE and EDGE; DIV is skipped when flat
// load: result through states LM1, LM2, LM3, LSUM and LOUT
// step: one result per component, read in SRD and output in SOUT, the last one flagged by last
// one transaction at a time; ready returns the cycle after the last result is taken
// rst clears control state and the edge registers; component stores undefined
module triangle_edge_walker_core import tew_pkg::*; #(
  parameter int COMPONENTS = COMPONENTS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int ROW_BITS = ROW_BITS_DEF
) (
  input logic clk,
  input logic rst,
  tew_if.sink in_ch,
  tew_if.source out_ch
);
  localparam int IW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam int F = FRACTION_BITS;
  localparam logic signed [33:0] RMAX = 34'sd1 << ROW_BITS;

  state_t state, state_next;
  logic signed [31:0] slope, edge_x;
  logic [F-1:0] prestep;
  logic [11:0] first_row, last_row;
  logic flat;
  logic signed [31:0] cur_mem [COMPONENTS];
  logic signed [31:0] step_mem [COMPONENTS];
  logic [IW-1:0] idx;
  logic signed [31:0] a_val, a_dx, a_dy, rd_cur, rd_step;
  logic signed [63:0] prod;
  logic signed [31:0] dxpre;
  logic signed [65:0] acc;
  div_req_t dreq;
  div_rsp_t drsp;

  tew_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  function automatic logic [11:0] ceil_row(input logic signed [31:0] y);
    logic signed [33:0] r;
    r = 34'(y >>> F) + ((y & ((32'sd1 <<< F) - 1)) != 0 ? 34'sd1 : 34'sd0);
    if (r < 0) r = 0;
    if (r > RMAX - 1) r = RMAX - 1;
    return r[11:0];
  endfunction

  wire take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && !out_ch.valid;
  wire out_free = !out_ch.valid || out_ch.ready;
  wire emit = out_free && (state == ST_EDGE || state == ST_LOUT || state == ST_SOUT);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    dreq.start = 1'b0;
    dreq.num = 64'(signed'(65'(in_ch.data.bottom_x) - 65'(in_ch.data.top_x)) <<< F);
    dreq.den = 33'(in_ch.data.bottom_y) - 33'(in_ch.data.top_y);
    case (state)
      ST_IDLE: if (take) begin
        case (in_ch.data.operation)
          OP_START: begin
            if (dreq.den == 0) state_next = ST_PRE;
            else begin
              dreq.start = 1'b1;
              state_next = ST_DIV;
            end
          end
          OP_LOAD: if ({1'b0, in_ch.data.component_index} < 5'(COMPONENTS))
            state_next = ST_LM1;
          OP_STEP: state_next = ST_SRD;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_DIV: if (drsp.done) state_next = ST_PRE;
      ST_PRE: state_next = ST_EDGE;
      ST_EDGE: if (out_free) state_next = ST_IDLE;
      ST_LM1: state_next = ST_LM2;
      ST_LM2: state_next = ST_LM3;
      ST_LM3: state_next = ST_LSUM;
      ST_LSUM: state_next = ST_LOUT;
      ST_LOUT: if (out_free) state_next = ST_IDLE;
      ST_SRD: state_next = ST_SOUT;
      ST_SOUT: if (out_free) state_next = (idx == IW'(COMPONENTS - 1)) ? ST_IDLE : ST_SRD;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slope <= '0; edge_x <= '0; prestep <= '0;
      first_row <= '0; last_row <= '0; flat <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (emit) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        ST_IDLE: if (take) begin
          a_val <= in_ch.data.attr_value;
          a_dx <= in_ch.data.attr_dfdx;
          a_dy <= in_ch.data.attr_dfdy;
          idx <= (in_ch.data.operation == OP_STEP) ? '0 : IW'(in_ch.data.component_index);
          if (in_ch.data.operation == OP_START) begin
            first_row <= ceil_row(in_ch.data.top_y);
            last_row <= ceil_row(in_ch.data.bottom_y);
            flat <= (dreq.den == 0);
            slope <= '0;
            edge_x <= in_ch.data.top_x;
            prestep <= (in_ch.data.top_y[F-1:0] != 0) ? F'(-in_ch.data.top_y[F-1:0]) : '0;
          end
        end
        ST_DIV: if (drsp.done) slope <= sat32(66'(drsp.quot));
        ST_PRE: prod <= $signed({1'b0, prestep}) * slope;
        ST_EDGE: if (out_free) begin
          edge_x <= sat32(66'(edge_x) + 66'(prod >>> F));
          out_ch.data.kind <= KIND_EDGE;
          out_ch.data.status <= flat;
          out_ch.data.row_first <= first_row;
          out_ch.data.row_last <= last_row;
          out_ch.data.x_current <= sat32(66'(edge_x) + 66'(prod >>> F));
          out_ch.data.out_component <= '0;
          out_ch.data.component_value <= '0;
          out_ch.data.last <= 1'b1;
        end
        ST_LM1: begin
          prod <= $signed({1'b0, prestep}) * slope;
          acc <= 66'(a_val);
        end
        ST_LM2: begin
          dxpre <= 32'(prod >>> F);
          prod <= a_dy * $signed({1'b0, prestep});
        end
        ST_LM3: begin
          acc <= acc + 66'(prod >>> F);
          prod <= a_dx * dxpre;
        end
        ST_LSUM: begin
          acc <= acc + 66'(prod >>> F);
          prod <= a_dx * slope;
        end
        ST_LOUT: if (out_free) begin
          cur_mem[idx] <= sat32(acc);
          step_mem[idx] <= sat32(66'(a_dy) + 66'(prod >>> F));
          out_ch.data.kind <= KIND_LOAD;
          out_ch.data.status <= flat;
          out_ch.data.row_first <= first_row;
          out_ch.data.row_last <= last_row;
          out_ch.data.x_current <= edge_x;
          out_ch.data.out_component <= 4'(idx);
          out_ch.data.component_value <= sat32(acc);
          out_ch.data.last <= 1'b1;
        end
        ST_SRD: begin
          rd_cur <= cur_mem[idx];
          rd_step <= step_mem[idx];
          if (idx == '0) edge_x <= sat32(66'(edge_x) + 66'(slope));
        end
        ST_SOUT: if (out_free) begin
          cur_mem[idx] <= sat32(66'(rd_cur) + 66'(rd_step));
          out_ch.data.kind <= KIND_STEP;
          out_ch.data.status <= flat;
          out_ch.data.row_first <= first_row;
          out_ch.data.row_last <= last_row;
          out_ch.data.x_current <= edge_x;
          out_ch.data.out_component <= 4'(idx);
          out_ch.data.component_value <= sat32(66'(rd_cur) + 66'(rd_step));
          out_ch.data.last <= (idx == IW'(COMPONENTS - 1));
          idx <= idx + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

### hw/rtl/tew_div.sv
// radix-2 restoring signed divider, truncating quotient, one bit per cycle
// depends on tew_pkg
module tew_div import tew_pkg::*; (
  input logic clk,
  input logic rst,
  input div_req_t req,
  output div_rsp_t rsp
);
  logic [63:0] rem, quo;
  logic [31:0] dmag;
  logic neg, busy, done;
  logic [6:0] cnt;
  logic [64:0] trial;
  always_comb trial = {rem, quo[63]} - {33'd0, dmag};
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= 7'd64;
      rem <= '0;
      quo <= req.num[63] ? 64'(-req.num) : req.num;
      dmag <= req.den[32] ? 32'(-req.den) : req.den[31:0];
      neg <= req.num[63] ^ req.den[32];
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
  assign rsp = {done, (neg ? 64'(-quo) : quo)};
endmodule

### hw/rtl/tew_checker.sv
// port-level checker for the edge walker, bound to the top level
// depends on tew_pkg and triangle_edge_walker_core_assert.svh
`include "triangle_edge_walker_core_assert.svh"
module tew_checker import tew_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_kind,
  input logic out_last,
  input logic [3:0] out_comp
);
  `TEW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `TEW_ASSERT_IMPL(a_no_take_busy, out_valid, !in_ready)
  `TEW_ASSERT_IMPL(a_edge_last, out_valid && out_kind == KIND_EDGE,
                   out_last && out_comp == 4'd0)
  `TEW_ASSERT_IMPL(a_kind_ok, out_valid, out_kind <= KIND_STEP)
endmodule

bind triangle_edge_walker_core tew_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.data.kind),
  .out_last(out_ch.data.last), .out_comp(out_ch.data.out_component)
);
